// ----- rtl/core/twt_pkg.sv -----
package twt_pkg;

  // Table geometry.
  localparam int SLOTS       = 256;
  localparam int CLAIM_BATCH = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int GOT_W       = $clog2(CLAIM_BATCH + 1);

  // Configuration register.
  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Operation codes.
  typedef enum logic [1:0] {
    FN_ADD     = 2'd0,
    FN_DELIVER = 2'd1,
    FN_POLL    = 2'd2,
    FN_DROP    = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_CLAIM = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        now_ms;
    logic [63:0]        req_key;
    logic [15:0]        open_options;
    logic [15:0]        stream_id;
    logic [19:0]        conn_fd;
    logic [63:0]        conn_serial;
    logic [21:0]        worker_id;
    logic [31:0]        life_ms;
    logic signed [31:0] done_code;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        row_key;
    logic [15:0]        row_options;
    logic [15:0]        row_stream;
    logic [19:0]        row_fd;
    logic [63:0]        row_serial;
    logic signed [31:0] row_code;
    logic               last;
  } rsp_t;

  // One stored row of the table.
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] options;
    logic [15:0] stream;
    logic [19:0] fd;
    logic [63:0] serial;
    logic [21:0] owner;
    logic [31:0] expiry;
    logic [31:0] code;
    logic        ready;
  } rec_t;

endpackage

// ----- rtl/core/twt_ram.sv -----
module twt_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [twt_pkg::SLOT_W-1:0] waddr_i,
  input  twt_pkg::rec_t             wdata_i,
  input  logic [twt_pkg::SLOT_W-1:0] raddr_i,
  output twt_pkg::rec_t             rdata_o
);
  import twt_pkg::*;

  rec_t mem [SLOTS];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/timed_waiter_table_core.sv -----
// Channel   Direction  Signals                    Handshake
// request   in         start_i, req_i, busy_o     taken when start_i and not busy_o
// result    out        done_o, rsp_o              done_o marks each result
// config    in         cfg_valid_i, cfg_data_i,   written when cfg_valid_i and cfg_ready_o
//                      cfg_ready_o
//
// Each operation sweeps the active slots through the row memory, one slot per
// cycle: add, drop and poll sweep them once, deliver twice, the second sweep being
// a poll; a poll that fills its batch ends early.
// The memory read port sets the one slot per cycle. Reset clears the used bits at once
// and the ready flag is rewritten by every add, so no clearing pass is needed.
// The receiver cannot stall: results leave on fixed cycles.
module timed_waiter_table_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  twt_pkg::req_t             req_i,
  output logic                      done_o,
  output twt_pkg::rsp_t             rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [twt_pkg::CFG_W-1:0] cfg_data_i
);
  import twt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [1:0]        mode_q, mode_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              proc_v_q, proc_v_d;
  logic [SLOT_W-1:0] proc_idx_q, proc_idx_d;
  logic              free_v_q, free_v_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic [GOT_W-1:0]  got_q, got_d;
  logic              pend_v_q, pend_v_d;
  rsp_t              pend_q, pend_d;
  logic [SLOTS-1:0]  used_q, used_d;
  req_t              req_q, req_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic              we;
  logic [SLOT_W-1:0] waddr;
  rec_t              wdata;
  rec_t              rdata;
  logic [CNT_W-1:0]  n;
  logic              cur_used;
  logic              expired;
  logic              last_slot;
  logic [31:0]       age;
  rsp_t              claim;

  twt_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (issue_q[SLOT_W-1:0]),
    .rdata_o (rdata)
  );

  // Active slot count, with zero and oversized values meaning the full table.
  always_comb begin
    if (cfg_q == '0 || 32'(cfg_q) > SLOTS) begin
      n = CNT_W'(SLOTS);
    end else begin
      n = CNT_W'(cfg_q);
    end
  end

  // Per-slot tests on the row read in the previous cycle.
  assign cur_used  = used_q[proc_idx_q];
  assign age       = req_q.now_ms - rdata.expiry;
  assign expired   = !age[31];
  assign last_slot = (CNT_W'(proc_idx_q) == n - CNT_W'(1));

  always_comb begin
    claim             = '0;
    claim.status      = ST_CLAIM;
    claim.row_key     = rdata.key;
    claim.row_options = rdata.options;
    claim.row_stream  = rdata.stream;
    claim.row_fd      = rdata.fd;
    claim.row_serial  = rdata.serial;
    claim.row_code    = rdata.code;
  end

  // Sequencer: one sweep over the slots per operation, two for deliver.
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    issue_d    = issue_q;
    proc_v_d   = proc_v_q;
    proc_idx_d = proc_idx_q;
    free_v_d   = free_v_q;
    free_idx_d = free_idx_q;
    got_d      = got_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    used_d     = used_q;
    req_d      = req_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    we         = 1'b0;
    waddr      = proc_idx_q;
    wdata      = rdata;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          mode_d   = req_i.func;
          issue_d  = '0;
          proc_v_d = 1'b0;
          free_v_d = 1'b0;
          got_d    = '0;
          pend_v_d = 1'b0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous slot is processed.
        if (issue_q < n) begin
          proc_v_d   = 1'b1;
          proc_idx_d = issue_q[SLOT_W-1:0];
          issue_d    = issue_q + CNT_W'(1);
        end else begin
          proc_v_d = 1'b0;
        end

        if (proc_v_q) begin
          unique case (mode_q)
            FN_ADD: begin
              if (cur_used && expired) begin
                used_d[proc_idx_q] = 1'b0;
              end
              if (!(cur_used && !expired) && !free_v_q) begin
                free_v_d   = 1'b1;
                free_idx_d = proc_idx_q;
              end
              if (last_slot) begin
                rsp_d      = '0;
                rsp_d.last = 1'b1;
                done_d     = 1'b1;
                state_d    = S_IDLE;
                if (free_v_d) begin
                  we                 = 1'b1;
                  waddr              = free_idx_d;
                  wdata.key          = req_q.req_key;
                  wdata.options      = req_q.open_options;
                  wdata.stream       = req_q.stream_id;
                  wdata.fd           = req_q.conn_fd;
                  wdata.serial       = req_q.conn_serial;
                  wdata.owner        = req_q.worker_id;
                  wdata.expiry       = req_q.now_ms + req_q.life_ms;
                  wdata.code         = '0;
                  wdata.ready        = 1'b0;
                  used_d[free_idx_d] = 1'b1;
                  rsp_d.status       = ST_DONE;
                end else begin
                  rsp_d.status = ST_FULL;
                end
              end
            end

            FN_DELIVER: begin
              if (cur_used && rdata.key == req_q.req_key) begin
                we          = 1'b1;
                wdata.ready = 1'b1;
                wdata.code  = req_q.done_code;
              end
              // The poll sweep follows straight on from slot zero.
              if (last_slot) begin
                mode_d   = FN_POLL;
                issue_d  = '0;
                proc_v_d = 1'b0;
              end
            end

            FN_POLL: begin
              if (cur_used) begin
                if (rdata.ready && rdata.owner == req_q.worker_id) begin
                  // Send the held claim and hold this one until its last flag is known.
                  if (pend_v_q) begin
                    rsp_d  = pend_q;
                    done_d = 1'b1;
                  end
                  pend_d             = claim;
                  pend_v_d           = 1'b1;
                  used_d[proc_idx_q] = 1'b0;
                  got_d              = got_q + GOT_W'(1);
                end else if (expired) begin
                  used_d[proc_idx_q] = 1'b0;
                end
              end
              if (last_slot || got_d == GOT_W'(CLAIM_BATCH)) begin
                state_d = S_FLUSH;
              end
            end

            FN_DROP: begin
              if (cur_used && rdata.fd == req_q.conn_fd && rdata.serial == req_q.conn_serial
                  && rdata.owner == req_q.worker_id) begin
                used_d[proc_idx_q] = 1'b0;
              end
              if (last_slot) begin
                rsp_d        = '0;
                rsp_d.status = ST_DONE;
                rsp_d.last   = 1'b1;
                done_d       = 1'b1;
                state_d      = S_IDLE;
              end
            end

            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_FLUSH: begin
        if (pend_v_q) begin
          rsp_d = pend_q;
        end else begin
          rsp_d        = '0;
          rsp_d.status = ST_NONE;
        end
        rsp_d.last = 1'b1;
        done_d     = 1'b1;
        pend_v_d   = 1'b0;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= FN_ADD;
      cfg_q    <= CFG_RESET;
      issue_q  <= '0;
      proc_v_q <= 1'b0;
      free_v_q <= 1'b0;
      got_q    <= '0;
      pend_v_q <= 1'b0;
      used_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      issue_q  <= issue_d;
      proc_v_q <= proc_v_d;
      free_v_q <= free_v_d;
      got_q    <= got_d;
      pend_v_q <= pend_v_d;
      used_q   <= used_d;
      done_q   <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    proc_idx_q <= proc_idx_d;
    free_idx_q <= free_idx_d;
    pend_q     <= pend_d;
    req_q      <= req_d;
    rsp_q      <= rsp_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- rtl/core/twt_checker.sv -----
module twt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input twt_pkg::rsp_t rsp_o,
  input logic          cfg_ready_o
);
  import twt_pkg::*;

  // An accepted item always starts a sweep.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("item accepted without going busy");

  // Only claimed rows can be followed by further results.
  a_more_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.last |-> rsp_o.status == ST_CLAIM)
    else $error("non-final result that is not a claim");

  // Results other than claims carry no row contents.
  a_zero_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_CLAIM |-> rsp_o.row_key == '0 && rsp_o.row_serial == '0
    && rsp_o.row_code == '0) else $error("row fields set on a non-claim result");

  // Configuration is taken exactly while no item is in work.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !busy_o) else $error("configuration ready while busy");

endmodule

bind timed_waiter_table_core twt_checker u_twt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .rsp_o       (rsp_o),
  .cfg_ready_o (cfg_ready_o)
);

// ----- tb/timed_waiter_table_core_test.sv -----
`timescale 1ns / 1ps

module timed_waiter_table_core_test;
  import twt_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  timed_waiter_table_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the table.
  logic [CFG_W-1:0] shadow_slots;
  logic        row_used [SLOTS];
  logic        row_ready [SLOTS];
  rec_t        row_data [SLOTS];

  req_t  pending_items [$];
  rsp_t  expected_rows [$];
  int    error_count;
  int    sent_count;
  int    gap_left;
  bit    drive_enable;
  logic  taken_q;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int active_count();
    if (shadow_slots == 0 || shadow_slots > SLOTS) return SLOTS;
    return int'(shadow_slots);
  endfunction

  function automatic bit is_expired(logic [31:0] now, logic [31:0] exp_t);
    logic [31:0] diff;
    diff = now - exp_t;
    return diff[31] == 1'b0;
  endfunction

  function automatic rsp_t plain_result(status_e st);
    rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Claim ready rows of one worker and reap expired rows on the way.
  task automatic predict_claims(logic [31:0] now, logic [21:0] who);
    int n;
    int got;
    rsp_t r;
    n = active_count();
    got = 0;
    for (int i = 0; i < n && got < CLAIM_BATCH; i++) begin
      if (!row_used[i]) continue;
      if (row_ready[i] && row_data[i].owner == who) begin
        r.status = ST_CLAIM;
        r.row_key = row_data[i].key;
        r.row_options = row_data[i].options;
        r.row_stream = row_data[i].stream;
        r.row_fd = row_data[i].fd;
        r.row_serial = row_data[i].serial;
        r.row_code = row_data[i].code;
        r.last = 1'b0;
        row_used[i] = 1'b0;
        got++;
        expected_rows.push_back(r);
        continue;
      end
      if (is_expired(now, row_data[i].expiry)) row_used[i] = 1'b0;
    end
    if (got == 0) expected_rows.push_back(plain_result(ST_NONE));
    else expected_rows[$].last = 1'b1;
  endtask

  // Predict the results of one accepted item.
  task automatic predict_item(req_t it);
    int n;
    int first_free;
    n = active_count();
    case (it.func)
      FN_ADD: begin
        first_free = n;
        for (int i = 0; i < n; i++) begin
          if (row_used[i] && is_expired(it.now_ms, row_data[i].expiry)) row_used[i] = 1'b0;
          if (!row_used[i] && first_free == n) first_free = i;
        end
        if (first_free == n) begin
          expected_rows.push_back(plain_result(ST_FULL));
        end else begin
          row_used[first_free] = 1'b1;
          row_ready[first_free] = 1'b0;
          row_data[first_free].key = it.req_key;
          row_data[first_free].options = it.open_options;
          row_data[first_free].stream = it.stream_id;
          row_data[first_free].fd = it.conn_fd;
          row_data[first_free].serial = it.conn_serial;
          row_data[first_free].owner = it.worker_id;
          row_data[first_free].expiry = it.now_ms + it.life_ms;
          row_data[first_free].code = '0;
          expected_rows.push_back(plain_result(ST_DONE));
        end
      end
      FN_DELIVER: begin
        for (int i = 0; i < n; i++) begin
          if (row_used[i] && row_data[i].key == it.req_key) begin
            row_ready[i] = 1'b1;
            row_data[i].code = it.done_code;
          end
        end
        predict_claims(it.now_ms, it.worker_id);
      end
      FN_POLL: predict_claims(it.now_ms, it.worker_id);
      default: begin
        for (int i = 0; i < n; i++) begin
          if (row_used[i] && row_data[i].fd == it.conn_fd &&
              row_data[i].serial == it.conn_serial && row_data[i].owner == it.worker_id)
            row_used[i] = 1'b0;
        end
        expected_rows.push_back(plain_result(ST_DONE));
      end
    endcase
  endtask

  // Driver: presents queued items with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && drive_enable) begin
      if (!start_i || taken_q) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          req_i <= pending_items.pop_front();
          start_i <= 1'b1;
          gap_left <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Acceptance is seen at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
    end else begin
      taken_q <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        predict_item(req_i);
        sent_count <= sent_count + 1;
      end
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, rsp_o);
        error_count++;
      end else begin
        rsp_t e;
        e = expected_rows.pop_front();
        if (rsp_o !== e) begin
          $display("%0t: result mismatch, expected %h, actual %h", $realtime, e, rsp_o);
          error_count++;
        end
      end
    end
  end

  // Fills an item with random content.
  function automatic req_t random_item(func_e f, logic [21:0] who, logic [63:0] key);
    req_t it;
    it.func = f;
    it.now_ms = 32'd1000 + $urandom_range(0, 200);
    it.req_key = key;
    it.open_options = 16'($urandom());
    it.stream_id = 16'($urandom());
    it.conn_fd = 20'($urandom_range(0, 3));
    it.conn_serial = {62'd0, 2'($urandom_range(0, 1))};
    it.worker_id = who;
    it.life_ms = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : 32'd100000;
    it.done_code = $urandom();
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || start_i || busy_o || expected_rows.size() > 0)
      @(posedge clk_i);
    repeat (2 * SLOTS + 20) @(posedge clk_i);
  endtask

  task automatic write_slots(logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow_slots = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int count);
    req_t it;
    logic [21:0] who;
    logic [63:0] key;
    logic [319:0] raw;
    int r;
    for (int k = 0; k < count; k++) begin
      who = ($urandom_range(0, 9) == 0) ? 22'($urandom()) : 22'($urandom_range(0, 2));
      key = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()} : 64'($urandom_range(0, 7));
      r = $urandom_range(0, 9);
      if (r < 4) it = random_item(FN_ADD, who, key);
      else if (r < 7) it = random_item(FN_DELIVER, who, key);
      else if (r < 9) it = random_item(FN_POLL, who, key);
      else it = random_item(FN_DROP, who, key);
      if ($urandom_range(0, 15) == 0) begin
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        it = raw[$bits(req_t)-1:0];
      end
      pending_items.push_back(it);
    end
  endtask

  // Stimulus.
  initial begin
    req_t it;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    error_count = 0;
    sent_count = 0;
    gap_left = 0;
    drive_enable = 1'b0;
    shadow_slots = CFG_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      row_used[i] = 1'b0;
      row_ready[i] = 1'b0;
      row_data[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    drive_enable = 1'b1;

    // Directed: small table filled to full, then extremes and wrap of expiry.
    write_slots(9'd4);
    for (int k = 0; k < 5; k++) begin
      it = random_item(FN_ADD, 22'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      it.life_ms = 32'd50;
      pending_items.push_back(it);
    end
    it = random_item(FN_DELIVER, 22'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    pending_items.push_back(it);
    it = random_item(FN_POLL, 22'd1, 64'd0);
    it.now_ms = 32'hFFFF_FFFF;
    pending_items.push_back(it);
    it = random_item(FN_ADD, 22'h3FFFFF, 64'd0);
    it.now_ms = 32'hFFFF_FFF0;
    it.life_ms = 32'h20;
    it.conn_fd = 20'hFFFFF;
    it.conn_serial = '1;
    it.open_options = '1;
    it.stream_id = '1;
    pending_items.push_back(it);
    it.func = FN_DELIVER;
    it.now_ms = 32'h5;
    it.done_code = 32'sh8000_0000;
    pending_items.push_back(it);
    it = random_item(FN_ADD, 22'd0, 64'd9);
    pending_items.push_back(it);
    it.func = FN_DROP;
    pending_items.push_back(it);
    it = random_item(FN_POLL, 22'd0, 64'd0);
    pending_items.push_back(it);
    wait_idle();

    // Batch limit: more than sixteen ready rows of one worker.
    write_slots(9'd0);
    for (int k = 0; k < 20; k++) begin
      it = random_item(FN_ADD, 22'd5, 64'd77);
      it.life_ms = 32'd100000;
      pending_items.push_back(it);
    end
    it = random_item(FN_DELIVER, 22'd5, 64'd77);
    pending_items.push_back(it);
    it.func = FN_POLL;
    pending_items.push_back(it);
    wait_idle();

    // Random phases over several table sizes.
    write_slots(9'd8);
    run_phase(120);
    wait_idle();
    write_slots(9'd1);
    run_phase(40);
    wait_idle();
    write_slots(9'd300);
    run_phase(60);
    wait_idle();
    write_slots(9'd24);
    run_phase(120);
    wait_idle();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(64'd40_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
